// ===== hw/rtl/mkd_pkg.sv =====
// Shared types and constants for the matrix keypad debouncer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mkd_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int SCAN_Q_DEPTH = 2;
  localparam int RESULT_CAP   = 16;
  localparam int LEVEL_BITS   = 16;
  localparam int LEVEL_IDX_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVENTS  = 2'd2;

  localparam logic [4:0]  KEY_COUNT_RST   = 5'd16;
  localparam logic [15:0] DEBOUNCE_MS_RST = 16'd20;
  localparam logic [4:0]  MAX_EVENTS_RST  = 5'd16;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] key_levels;
  } scan_t;

  typedef struct packed {
    logic [4:0]  key_count;
    logic [15:0] debounce_ms;
    logic [4:0]  max_events;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mkd_scan_fifo.sv =====
// Short queue of accepted scans between the stream input and the key walker.
// Depends on mkd_pkg for the scan type and default depth.
`default_nettype none

module mkd_scan_fifo import mkd_pkg::*; #(
  parameter int DEPTH = SCAN_Q_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire scan_t in_scan,
  output logic       out_valid,
  input  wire logic  out_pop,
  output scan_t      out_scan
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scan_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           push;
  logic           pop;

  assign in_ready  = (fill != CW'(DEPTH));
  assign out_valid = (fill != '0);
  assign out_scan  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mkd_walker.sv =====
// Key walker: updates raw levels and change times, applies the debounce rule
// and emits key events through an output register. Depends on mkd_pkg.
`default_nettype none

module mkd_walker import mkd_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  scan_valid,
  output logic       scan_pop,
  input  wire scan_t scan,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output logic [7:0] m_tdata,   // key_index[3:0], pressed[4], zero pad [7:5]
  output logic       m_tlast    // last_event
);

  localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KCW = $clog2(MAX_KEYS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]          state;
  logic [KW-1:0]       idx;
  logic [4:0]          cnt;
  logic [15:0]         levels;
  logic [31:0]         now;
  logic [MAX_KEYS-1:0] raw_lv;
  logic [MAX_KEYS-1:0] stable_lv;
  logic [MAX_KEYS-1:0] time_vld;
  logic [31:0]         ct_mem [MAX_KEYS];
  logic [31:0]         ct_rd;
  logic                tv_rd;
  logic                pend_valid;
  logic [3:0]          pend_idx;
  logic                pend_lvl;
  logic                out_valid;
  logic [3:0]          out_idx;
  logic                out_lvl;
  logic                out_last;

  logic [KCW-1:0]      keys;
  logic [4:0]          limit;
  logic                lvl;
  logic                changed;
  logic [31:0]         ct_eff;
  logic [31:0]         elapsed;
  logic                fire;
  logic                out_free;
  logic                last_key;
  logic                eval_go;
  logic                push_mid;
  logic                push_end;

  assign keys  = (32'(cfg.key_count) > MAX_KEYS) ? KCW'(MAX_KEYS) : KCW'(cfg.key_count);
  assign limit = (cfg.max_events > 5'(RESULT_CAP)) ? 5'(RESULT_CAP) : cfg.max_events;

  assign lvl      = (32'(idx) < LEVEL_BITS) ? levels[LEVEL_IDX_W'(idx)] : 1'b0;
  assign changed  = (lvl != raw_lv[idx]);
  assign ct_eff   = changed ? now : (tv_rd ? ct_rd : 32'd0);
  assign elapsed  = now - ct_eff;
  assign fire     = (lvl != stable_lv[idx]) && (elapsed >= {16'd0, cfg.debounce_ms})
                    && (cnt < limit);
  assign out_free = !out_valid || m_tready;
  assign last_key = ((32'(idx) + 32'd1) == 32'(keys));

  assign eval_go  = (state == S_EVAL) && !(fire && pend_valid && !out_free);
  assign push_mid = (state == S_EVAL) && fire && pend_valid && out_free;
  assign push_end = (state == S_FLUSH) && pend_valid && out_free;
  assign scan_pop = (state == S_IDLE) && scan_valid;

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_lvl, out_idx};
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      ct_rd <= ct_mem[idx];
    end
    if (eval_go && changed) begin
      ct_mem[idx] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_pop) begin
      levels <= scan.key_levels;
      now    <= scan.now_ms;
    end
    if (push_mid || push_end) begin
      out_idx  <= pend_idx;
      out_lvl  <= pend_lvl;
      out_last <= push_end;
    end
    if (eval_go && fire) begin
      pend_idx <= 4'(idx);
      pend_lvl <= lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      cnt        <= '0;
      raw_lv     <= '0;
      stable_lv  <= '0;
      time_vld   <= '0;
      tv_rd      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_mid || push_end) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (scan_valid && (keys != '0)) begin
            idx   <= '0;
            cnt   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          tv_rd <= time_vld[idx];
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (eval_go) begin
            if (changed) begin
              raw_lv[idx]   <= lvl;
              time_vld[idx] <= 1'b1;
            end
            if (fire) begin
              stable_lv[idx] <= lvl;
              pend_valid     <= 1'b1;
              cnt            <= cnt + 5'd1;
            end
            if (last_key) begin
              state <= S_FLUSH;
            end else begin
              idx   <= idx + KW'(1);
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_keypad_debouncer.sv =====
// Top level of the matrix keypad debouncer: configuration registers, scan
// queue and key walker. Depends on mkd_pkg, mkd_scan_fifo and mkd_walker.
//
// Each request on the input stream is one keypad scan; each request on the
// output stream is one debounced key event, with tlast on the final event of
// its scan, and a scan with no events produces nothing. Accepted scans wait in
// a short queue while the walker handles earlier ones, so the input keeps
// taking requests while events are pending, until the queue is full. For each
// key in use the walker reads the change-time memory, then evaluates the key;
// each scan ends in a flush of its pending last event, and evaluation and
// flush can wait while the output stalls. Configuration is written through a
// plain write port and must only change while the block is idle.
`default_nettype none

module matrix_keypad_debouncer import mkd_pkg::*; #(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int QUEUE_DEPTH = SCAN_Q_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,   // key_levels[15:0], now_ms[47:16]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // key_index[3:0], pressed[4], pad [7:5]
  output logic                       m_tlast,   // last_event
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  scan_t in_scan;
  scan_t q_scan;
  logic  q_valid;
  logic  q_pop;

  assign in_scan.key_levels = s_tdata[15:0];
  assign in_scan.now_ms     = s_tdata[47:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_count   <= KEY_COUNT_RST;
      cfg.debounce_ms <= DEBOUNCE_MS_RST;
      cfg.max_events  <= MAX_EVENTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_COUNT:   cfg.key_count   <= cfg_data[4:0];
        REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data;
        REG_MAX_EVENTS:  cfg.max_events  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  mkd_scan_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_scan  (in_scan),
    .out_valid(q_valid),
    .out_pop  (q_pop),
    .out_scan (q_scan)
  );

  mkd_walker #(
    .MAX_KEYS(MAX_KEYS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .scan_valid(q_valid),
    .scan_pop  (q_pop),
    .scan      (q_scan),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
